### rtl/sha256_hash_engine_unit_defines.svh
// Assertion macros for the SHA-256 hash engine.
// Used by the top level only; no other dependencies.
`ifndef SHA256_HASH_ENGINE_UNIT_DEFINES_SVH
`define SHA256_HASH_ENGINE_UNIT_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define SHA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sha_pkg.sv
// Package for the SHA-256 hash engine: types, round constants, helper functions.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a byte
    ST_ROUND,   // one compression round per cycle
    ST_FINAL,   // add working vars into hash words
    ST_PAD,     // insert one padding or length byte
    ST_EMIT     // present digest words
  } sha_state_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

### rtl/sha256_hash_engine_unit.sv
// SHA-256 engine with a single round unit; a byte that fills a block starts a
// compression of 64 rounds and a final add, and no byte is taken meanwhile.
// A last transaction adds padding bytes (and their compressions) and
// then 8 digest transactions, h0 first. Synchronous active-low reset restores
// the initial hash words and clears the length; block storage is not cleared.
`timescale 1ns / 1ps
`include "sha256_hash_engine_unit_defines.svh"

module sha256_hash_engine_unit
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // byte_present
  input  logic        in_tlast,    // last_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast    // last_word
);

  sha_state_t  state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [63:0] len_r, len_snap_r;
  logic [5:0]  pos_r;
  logic [5:0]  rnd_r;
  logic        fin_r;      // padding in progress
  logic [3:0]  pad_cnt_r;  // zero fill: nonzero once 0x80 is in; length phase: byte index 0..8
  logic        len_phase_r;
  logic [2:0]  out_idx_r;

  // Byte entering the block this cycle
  logic        put;
  logic [7:0]  put_byte;
  logic [3:0]  wi;
  logic [4:0]  sh;

  logic [31:0] wt, t1, t2;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {5'd0, out_idx_r, h_r[out_idx_r]};
  assign out_tlast  = (out_idx_r == 3'd7);

  wire in_fire = in_tvalid && in_tready;

  // Byte source: input byte or padding byte
  always_comb begin
    put = 1'b0;
    put_byte = in_tdata;
    if (state_r == ST_IDLE) begin
      put = in_fire && in_tuser;
    end else if (state_r == ST_PAD) begin
      put = 1'b1;
      if (len_phase_r)
        put_byte = len_snap_r[63 - 8 * pad_cnt_r[2:0] -: 8];
      else if (pad_cnt_r == 4'd0)
        put_byte = PAD_BYTE;
      else
        put_byte = 8'h00;
    end
    wi = pos_r[5:2];
    sh = 5'd24 - {pos_r[1:0], 3'b000};
  end

  // Shared round unit
  always_comb begin
    if (rnd_r < 6'd16)
      wt = w_r[rnd_r[3:0]];
    else
      wt = w_r[rnd_r[3:0]] + small_sig0(w_r[rnd_r[3:0] + 4'd1]) +
           w_r[rnd_r[3:0] + 4'd9] + small_sig1(w_r[rnd_r[3:0] + 4'd14]);
    t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) +
         ROUND_K[rnd_r] + wt;
    t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (put && pos_r == 6'd63) state_nxt = ST_ROUND;
          else if (in_tlast)         state_nxt = ST_PAD;
        end
      end
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_FINAL;
      ST_FINAL: state_nxt = fin_r ? (len_phase_r && pad_cnt_r == 4'd8 ? ST_EMIT : ST_PAD)
                                  : ST_IDLE;
      ST_PAD: if (pos_r == 6'd63) state_nxt = ST_ROUND;
      ST_EMIT: if (out_tready && out_idx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r <= '0;
      pos_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      pad_cnt_r <= '0;
      len_phase_r <= 1'b0;
      out_idx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && put) len_r <= len_r + 64'd8;
      if (state_r == ST_IDLE && in_fire && in_tlast) begin
        fin_r <= 1'b1;
        len_phase_r <= 1'b0;
        pad_cnt_r <= '0;
        len_snap_r <= len_r + (put ? 64'd8 : 64'd0);
      end
      if (put) pos_r <= pos_r + 6'd1;
      // Padding progress: 0x80 first, zeros to byte 56, then eight length bytes
      if (state_r == ST_PAD) begin
        if (len_phase_r) begin
          pad_cnt_r <= pad_cnt_r + 4'd1;
        end else if (pos_r == 6'd55) begin
          len_phase_r <= 1'b1;
          pad_cnt_r <= '0;
        end else begin
          pad_cnt_r <= 4'd1;
        end
      end
      if (state_r == ST_ROUND) rnd_r <= rnd_r + 6'd1;
      if (state_r == ST_FINAL)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (state_r == ST_EMIT && out_tready) begin
        out_idx_r <= out_idx_r + 3'd1;
        if (out_idx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
          len_r <= '0;
          pos_r <= '0;
          fin_r <= 1'b0;
          len_phase_r <= 1'b0;
          pad_cnt_r <= '0;
        end
      end
    end
  end

  // Datapath: block buffer, schedule window, working variables
  always_ff @(posedge clk) begin
    if (put) w_r[wi] <= (w_r[wi] & ~(32'hff << sh)) | ({24'd0, put_byte} << sh);
    if (state_r == ST_ROUND) begin
      w_r[rnd_r[3:0]] <= wt;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else if (put && pos_r == 6'd63) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
  end

  `SHA_ASSERT_IMPL(a_ready_idle, in_tready, !out_tvalid, "ready while emitting")
  `SHA_ASSERT_NEXT(a_round_end, state_r == ST_ROUND && rnd_r == 6'd63, state_r == ST_FINAL,
                   "round count did not end compression")
  `SHA_ASSERT_IMPL(a_round_pos, state_r == ST_ROUND, pos_r == 6'd0, "compression mid-block")

endmodule

### sim/testbench.sv
// Self-checking testbench for the SHA-256 hash engine (sha256_hash_engine_unit).
// Depends on sha_pkg for PAD_BYTE; the stream types and the digest predictor are local.
`timescale 1ns / 1ps

module testbench;
  import sha_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_item;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  // One directed row: the transaction, and the first digest word where it is known
  typedef struct packed {
    msg_item_t   it;
    logic        chk;
    logic [31:0] h0;
  } dir_row_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam int LIMIT = 2000000;

  // First digest words that can be read off at a glance
  localparam logic [31:0] EMPTY_H0 = 32'he3b0c442;
  localparam logic [31:0] ABC_H0   = 32'hba7816bf;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] data_byte
  logic        in_tuser = 1'b0;   // byte_present
  logic        in_tlast = 1'b0;   // last_item
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] digest_word, [34:32] word_index, rest zero
  logic        out_tlast;         // last_word

  sha256_hash_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [31:0] hash_st [8];
  logic [7:0]  blk_bytes [64];
  logic [5:0]  blk_pos;
  logic [63:0] msg_bits;

  digest_out_t digest_q [$];
  int          errors = 0;
  int          cycles = 0;
  bit          rx_idle_on = 1'b1;
  bit          rx_hold = 1'b0;
  bit          stim_done = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of the buffered block
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + KTAB[r] + w[r];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endtask

  task automatic append_byte(logic [7:0] b);
    blk_bytes[blk_pos] = b;
    blk_pos++;
    if (blk_pos == 0) compress_block();
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) hash_st[i] = IV[i];
    msg_bits = '0;
    blk_pos = '0;
  endtask

  // Feed one accepted transaction into the digest predictor
  task automatic predict_digest(msg_item_t it);
    logic [63:0] len;
    digest_out_t d;
    if (it.byte_present) begin
      append_byte(it.data_byte);
      msg_bits += 64'd8;
    end
    if (it.last_item) begin
      len = msg_bits;
      append_byte(PAD_BYTE);
      while (blk_pos != 6'd56) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_st[i];
        d.word_index = 3'(i);
        d.last_word = (i == 7);
        digest_q.push_back(d);
      end
      restart_digest();
    end
  endtask

  // Send one transaction, with random idle cycles when enabled
  task automatic send_item(msg_item_t it, bit idle_on);
    while (idle_on && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    {in_tdata, in_tuser, in_tlast} <= it;
    do @(posedge clk); while (!in_tready);
    predict_digest(it);
  endtask

  task automatic send_message(int len, bit byte_on_last, bit idle_on);
    msg_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = 8'($urandom);
      it.byte_present = 1'b1;
      it.last_item = 1'b0;
      // occasional empty non-last transaction
      if ($urandom_range(19) == 0) it.byte_present = 1'b0;
      send_item(it, idle_on);
    end
    it.data_byte = 8'($urandom);
    it.byte_present = byte_on_last;
    it.last_item = 1'b1;
    send_item(it, idle_on);
  endtask

  // Result checker
  always @(posedge clk) begin
    digest_out_t got, want;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (out_tvalid && out_tready) begin
        got.digest_word = out_tdata[31:0];
        got.word_index = out_tdata[34:32];
        got.last_word = out_tlast;
        if (digest_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected digest word %h idx %0d",
                                     got.digest_word, got.word_index);
        end else begin
          want = digest_q.pop_front();
          if (got !== want || out_tdata[39:35] !== '0) begin
            errors++;
            if (errors <= 10)
              $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                       want.digest_word, want.word_index, want.last_word,
                       got.digest_word, got.word_index, got.last_word);
          end
        end
      end
      if (cycles > LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Receiver ready: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (rx_hold) out_tready <= 1'b0;
    else if (rx_idle_on) out_tready <= ($urandom_range(99) >= 25);
    else out_tready <= 1'b1;
  end

  // Long receiver hold-off, counted in its own process
  initial begin
    wait (stim_done == 1'b0 && rst_n);
    @(posedge clk);
    wait (digest_q.size() >= 8);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Directed table: transaction (data_byte, byte_present, last_item), check flag, h0
  dir_row_t dir_tab [] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_H0},   // empty message
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_H0},     // "abc"
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, 32'h0},      // ignored item
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, 32'h0},      // single byte on the last item
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h55, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{8'haa, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h80, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h7f, 1'b0, 1'b1}, 1'b0, 32'h0}
  };

  initial begin
    restart_digest();
    for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // known first words sit at the head of the eight just queued
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].it, 1'b0);
      if (dir_tab[i].chk &&
          digest_q[digest_q.size() - 8].digest_word !== dir_tab[i].h0) begin
        errors++;
        if (errors <= 10)
          $display("known digest mismatch: exp %h got %h", dir_tab[i].h0,
                   digest_q[digest_q.size() - 8].digest_word);
      end
    end

    // padding boundaries: 55, 56, 63, 64 bytes
    send_message(54, 1'b1, 1'b1);
    send_message(56, 1'b0, 1'b1);
    send_message(63, 1'b0, 1'b1);
    send_message(63, 1'b1, 1'b0);   // no idling stretch

    // sender pause until every digest word has come
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (digest_q.size() == 0);

    // random messages, mostly short, a few longer
    for (int m = 0; m < 6; m++)
      send_message(($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12),
                   1'($urandom_range(1)), 1'b1);
    rx_idle_on = 1'b0;
    for (int m = 0; m < 4; m++)
      send_message($urandom_range(8), 1'($urandom_range(1)), 1'b0);

    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    @(posedge clk);
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
